// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked assertions, all on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge.
`define NLTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("nlts check failed");

// Same-cycle implication.
`define NLTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nlts check failed");

// Next-cycle implication.
`define NLTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nlts check failed");

`endif

// File: sv/nlts_pkg.sv
// ---------------------------------------------------------------------------
// nlts_pkg
// Shared types and constants for the nearest light selection core.
// ---------------------------------------------------------------------------
package nlts_pkg;

  localparam int MAX_LIGHTS  = 16;
  localparam int COORD_BITS  = 24;
  localparam int SLOT_BITS   = $clog2(MAX_LIGHTS);
  localparam int COUNT_BITS  = $clog2(MAX_LIGHTS + 1);
  localparam int DIST_BITS   = 2 * (COORD_BITS + 1);
  localparam int LEVEL_BITS  = 16;
  localparam int FALL_BITS   = 16;
  localparam int NUM_AXES    = 3;
  localparam int STEP_BITS   = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [DIST_BITS-1:0]         dist_t;
  typedef logic [SLOT_BITS-1:0]         slot_t;
  typedef logic [COUNT_BITS-1:0]        count_t;

  typedef struct packed {
    dist_t                        distance;
    coord_t                       x;
    coord_t                       y;
    coord_t                       z;
    logic signed [LEVEL_BITS-1:0] level;
    logic [FALL_BITS-1:0]         falloff;
  } entry_t;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_OFFER = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_CAPACITY = 2'd0,
    REG_CAMERA_X = 2'd1,
    REG_CAMERA_Y = 2'd2,
    REG_CAMERA_Z = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_READ_DATA,
    S_DIST,
    S_DECIDE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

// File: sv/nlts_dist.sv
// ---------------------------------------------------------------------------
// nlts_dist
// Squared distance unit: one subtractor and one multiplier reused per axis.
// ---------------------------------------------------------------------------
module nlts_dist (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  nlts_pkg::coord_t pos_x,
  input  nlts_pkg::coord_t pos_y,
  input  nlts_pkg::coord_t pos_z,
  input  nlts_pkg::coord_t cam_x,
  input  nlts_pkg::coord_t cam_y,
  input  nlts_pkg::coord_t cam_z,
  output logic            done,
  output nlts_pkg::dist_t sq_dist
);

  logic                                  busy;
  logic [nlts_pkg::STEP_BITS-1:0]        step;
  logic                                  abs_vld;
  logic                                  prod_vld;
  nlts_pkg::coord_t                      sel_pos;
  nlts_pkg::coord_t                      sel_cam;
  logic signed [nlts_pkg::COORD_BITS:0]  diff;
  logic [nlts_pkg::COORD_BITS:0]         absd;
  nlts_pkg::dist_t                       prod;
  nlts_pkg::dist_t                       acc;

  always_comb begin
    case (step)
      nlts_pkg::STEP_BITS'(0): begin
        sel_pos = pos_x;
        sel_cam = cam_x;
      end
      nlts_pkg::STEP_BITS'(1): begin
        sel_pos = pos_y;
        sel_cam = cam_y;
      end
      default: begin
        sel_pos = pos_z;
        sel_cam = cam_z;
      end
    endcase
  end

  assign diff = $signed({sel_pos[nlts_pkg::COORD_BITS-1], sel_pos})
              - $signed({sel_cam[nlts_pkg::COORD_BITS-1], sel_cam});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step     <= '0;
      abs_vld  <= 1'b0;
      prod_vld <= 1'b0;
      done     <= 1'b0;
    end else if (start) begin
      busy     <= 1'b1;
      step     <= '0;
      abs_vld  <= 1'b0;
      prod_vld <= 1'b0;
      done     <= 1'b0;
    end else if (busy) begin
      step     <= step + nlts_pkg::STEP_BITS'(1);
      abs_vld  <= (step < nlts_pkg::STEP_BITS'(nlts_pkg::NUM_AXES));
      prod_vld <= abs_vld;
      if (step == nlts_pkg::STEP_BITS'(nlts_pkg::NUM_AXES + 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // abs -> square -> accumulate, one axis entering per cycle
  always_ff @(posedge clk) begin
    absd <= diff[nlts_pkg::COORD_BITS] ? (nlts_pkg::COORD_BITS+1)'(-diff)
                                       : (nlts_pkg::COORD_BITS+1)'(diff);
    prod <= absd * absd;
    if (start) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + prod;
    end
  end

  assign sq_dist = acc;

endmodule

// File: sv/nlts_table.sv
// ---------------------------------------------------------------------------
// nlts_table
// Light entry store: one write port, one registered read port.
// ---------------------------------------------------------------------------
module nlts_table (
  input  logic             clk,
  input  logic             we,
  input  nlts_pkg::slot_t  waddr,
  input  nlts_pkg::entry_t wdata,
  input  nlts_pkg::slot_t  raddr,
  output nlts_pkg::entry_t rdata
);

  nlts_pkg::entry_t mem [nlts_pkg::MAX_LIGHTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/nearest_light_top_k_select_core.sv
// ---------------------------------------------------------------------------
// nearest_light_top_k_select_core
// Keeps the lights nearest the camera in a small table; clear, offer, read.
// ---------------------------------------------------------------------------
//  port group   dir  contents
//  s_axis_*     in   tuser: action; tdata: light, position, level, falloff, index
//  m_axis_*     out  tuser: accepted; tdata: slot, total, entry fields
//  cfg_*        in   capacity and camera position writes
//
//  Clear, unknown action, skipped offer: IDLE, DONE, then the output register.
//  Read: IDLE, READ (one registered table read), READ_DATA, DONE.
//  Offer: IDLE, DIST (the shared subtract/square unit), DECIDE, DONE.
//  A replacement adds a SCAN state that rescans the valid entries.
//  Sync reset empties the table; a result held by m_axis_tready stalls the
//  core in its final cycle until taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_light_top_k_select_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [0] light_on, [24:1] pos_x, [48:25] pos_y, [72:49] pos_z,
  // [88:73] light_level, [104:89] light_falloff, [108:105] read_index
  input  logic [111:0]  s_axis_tdata,
  // [1:0] action
  input  logic [1:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [3:0] slot, [8:4] entry_total, [58:9] out_distance, [82:59] out_x,
  // [106:83] out_y, [130:107] out_z, [146:131] out_level,
  // [162:147] out_falloff
  output logic [167:0]  m_axis_tdata,
  // [0] accepted
  output logic          m_axis_tuser,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [23:0]   cfg_data
);

  nlts_pkg::state_t  state, state_next;

  // latched item
  logic [1:0]        it_act;
  nlts_pkg::coord_t  it_x, it_y, it_z;
  logic signed [nlts_pkg::LEVEL_BITS-1:0] it_level;
  logic [nlts_pkg::FALL_BITS-1:0]         it_falloff;
  nlts_pkg::slot_t   it_ridx;

  // configuration
  nlts_pkg::count_t  capacity;
  nlts_pkg::coord_t  cam_x, cam_y, cam_z;

  // table bookkeeping
  nlts_pkg::count_t  count;
  nlts_pkg::dist_t   far_dist;
  nlts_pkg::slot_t   far_slot;
  nlts_pkg::count_t  scan_addr;
  logic              scan_pend;
  nlts_pkg::slot_t   scan_idx;

  // result staging and output register
  logic              res_acc;
  nlts_pkg::slot_t   res_slot;
  nlts_pkg::entry_t  res_entry;
  logic              o_acc;
  nlts_pkg::slot_t   o_slot;
  nlts_pkg::count_t  o_total;
  nlts_pkg::entry_t  o_entry;
  logic              o_valid;

  logic              in_beat;
  logic              in_on;
  logic signed [nlts_pkg::LEVEL_BITS-1:0] in_level;
  logic              offer_go;
  logic              out_free;
  nlts_pkg::count_t  cap_eff;
  logic              fill_ok;
  logic              repl_ok;

  logic              tbl_we;
  nlts_pkg::slot_t   tbl_waddr;
  nlts_pkg::entry_t  tbl_wdata;
  nlts_pkg::slot_t   tbl_raddr;
  nlts_pkg::entry_t  tbl_rdata;
  logic              dist_start;
  logic              dist_done;
  nlts_pkg::dist_t   dist_val;

  assign in_on    = s_axis_tdata[0];
  assign in_level = s_axis_tdata[88:73];
  assign offer_go = in_on && (in_level != '0);
  assign out_free = !o_valid || m_axis_tready;
  assign cap_eff  = (capacity > nlts_pkg::COUNT_BITS'(nlts_pkg::MAX_LIGHTS))
                  ? nlts_pkg::COUNT_BITS'(nlts_pkg::MAX_LIGHTS) : capacity;
  assign fill_ok  = count < cap_eff;
  assign repl_ok  = !fill_ok && (dist_val < far_dist);

  nlts_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .start   (dist_start),
    .pos_x   (it_x),
    .pos_y   (it_y),
    .pos_z   (it_z),
    .cam_x   (cam_x),
    .cam_y   (cam_y),
    .cam_z   (cam_z),
    .done    (dist_done),
    .sq_dist (dist_val)
  );

  nlts_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      nlts_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          case (nlts_pkg::action_t'(s_axis_tuser))
            nlts_pkg::ACT_OFFER: state_next = offer_go ? nlts_pkg::S_DIST
                                                       : nlts_pkg::S_DONE;
            nlts_pkg::ACT_READ:  state_next = nlts_pkg::S_READ;
            default:             state_next = nlts_pkg::S_DONE;
          endcase
        end
      end
      nlts_pkg::S_READ:      state_next = nlts_pkg::S_READ_DATA;
      nlts_pkg::S_READ_DATA: state_next = nlts_pkg::S_DONE;
      nlts_pkg::S_DIST: begin
        if (dist_done) begin
          state_next = nlts_pkg::S_DECIDE;
        end
      end
      nlts_pkg::S_DECIDE:    state_next = repl_ok ? nlts_pkg::S_SCAN : nlts_pkg::S_DONE;
      nlts_pkg::S_SCAN: begin
        if ((scan_addr == count) && !scan_pend) begin
          state_next = nlts_pkg::S_DONE;
        end
      end
      nlts_pkg::S_DONE: begin
        if (out_free) begin
          state_next = nlts_pkg::S_IDLE;
        end
      end
      default:               state_next = nlts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == nlts_pkg::S_IDLE);
    in_beat       = s_axis_tvalid && s_axis_tready;
    dist_start    = in_beat && offer_go
                 && (s_axis_tuser == nlts_pkg::ACT_OFFER);
    tbl_we        = (state == nlts_pkg::S_DECIDE) && (fill_ok || repl_ok);
    tbl_waddr     = fill_ok ? count[nlts_pkg::SLOT_BITS-1:0] : far_slot;
    tbl_raddr     = (state == nlts_pkg::S_READ) ? it_ridx
                                                : scan_addr[nlts_pkg::SLOT_BITS-1:0];
    tbl_wdata.distance = dist_val;
    tbl_wdata.x        = it_x;
    tbl_wdata.y        = it_y;
    tbl_wdata.z        = it_z;
    tbl_wdata.level    = it_level;
    tbl_wdata.falloff  = it_falloff;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nlts_pkg::S_IDLE;
      capacity  <= nlts_pkg::COUNT_BITS'(nlts_pkg::MAX_LIGHTS);
      cam_x     <= '0;
      cam_y     <= '0;
      cam_z     <= '0;
      count     <= '0;
      far_dist  <= '0;
      far_slot  <= '0;
      scan_addr <= '0;
      scan_pend <= 1'b0;
      o_valid   <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (nlts_pkg::cfg_reg_t'(cfg_index))
          nlts_pkg::REG_CAPACITY: capacity <= cfg_data[nlts_pkg::COUNT_BITS-1:0];
          nlts_pkg::REG_CAMERA_X: cam_x    <= cfg_data;
          nlts_pkg::REG_CAMERA_Y: cam_y    <= cfg_data;
          nlts_pkg::REG_CAMERA_Z: cam_z    <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        nlts_pkg::S_IDLE: begin
          if (in_beat && (s_axis_tuser == nlts_pkg::ACT_CLEAR)) begin
            count    <= '0;
            far_dist <= '0;
            far_slot <= '0;
          end
        end
        nlts_pkg::S_DECIDE: begin
          if (fill_ok) begin
            if ((count == '0) || (dist_val >= far_dist)) begin
              far_dist <= dist_val;
              far_slot <= count[nlts_pkg::SLOT_BITS-1:0];
            end
            count <= count + nlts_pkg::COUNT_BITS'(1);
          end else if (repl_ok) begin
            scan_addr <= '0;
            scan_pend <= 1'b0;
          end
        end
        nlts_pkg::S_SCAN: begin
          // read issued one cycle, compared the next; ties keep lowest slot
          if (scan_addr < count) begin
            scan_addr <= scan_addr + nlts_pkg::COUNT_BITS'(1);
            scan_pend <= 1'b1;
          end else begin
            scan_pend <= 1'b0;
          end
          if (scan_pend && ((scan_idx == '0) || (tbl_rdata.distance > far_dist))) begin
            far_dist <= tbl_rdata.distance;
            far_slot <= scan_idx;
          end
        end
        default: ;
      endcase

      if (state == nlts_pkg::S_DONE && out_free) begin
        o_valid <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      it_act     <= s_axis_tuser;
      it_x       <= s_axis_tdata[24:1];
      it_y       <= s_axis_tdata[48:25];
      it_z       <= s_axis_tdata[72:49];
      it_level   <= s_axis_tdata[88:73];
      it_falloff <= s_axis_tdata[104:89];
      it_ridx    <= s_axis_tdata[108:105];
      res_acc    <= 1'b0;
      res_slot   <= '0;
      res_entry  <= '0;
    end

    if (state == nlts_pkg::S_SCAN) begin
      scan_idx <= scan_addr[nlts_pkg::SLOT_BITS-1:0];
    end

    if (state == nlts_pkg::S_READ_DATA) begin
      res_slot  <= it_ridx;
      res_entry <= (nlts_pkg::COUNT_BITS'(it_ridx) < count) ? tbl_rdata : '0;
    end

    if (state == nlts_pkg::S_DECIDE) begin
      if (fill_ok) begin
        res_acc  <= 1'b1;
        res_slot <= count[nlts_pkg::SLOT_BITS-1:0];
      end else if (repl_ok) begin
        res_acc  <= 1'b1;
        res_slot <= far_slot;
      end
    end

    if (state == nlts_pkg::S_DONE && out_free) begin
      o_acc   <= res_acc;
      o_slot  <= res_slot;
      o_total <= count;
      o_entry <= res_entry;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tuser  = o_acc;
  assign m_axis_tdata  = {5'b0, o_entry.falloff, o_entry.level, o_entry.z, o_entry.y,
                          o_entry.x, o_entry.distance, o_total, o_slot};

  `NLTS_ASSERT_IMP(a_far_slot_valid, count != '0, nlts_pkg::COUNT_BITS'(far_slot) < count)
  `NLTS_ASSERT_IMP(a_dist_done_wait, dist_done, state == nlts_pkg::S_DIST)
  `NLTS_ASSERT_NXT(a_write_follow, tbl_we, state == nlts_pkg::S_SCAN || state == nlts_pkg::S_DONE)
  `NLTS_ASSERT_IMP(a_scan_bound, state == nlts_pkg::S_SCAN, scan_addr <= count)
  `NLTS_ASSERT_IMP(a_offer_kind, state == nlts_pkg::S_DIST, it_act == nlts_pkg::ACT_OFFER)

endmodule
